// File: rtl/tpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the timer pool engine: command, state, event and status codes,
// and the result and memory control types. No dependencies.
package tpe_pkg;

  // field widths fixed by the interface
  localparam int CMD_W   = 3;
  localparam int ID_W    = 5;
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 6;
  localparam int CNT_W   = 6;   // scan counter, holds 0..32

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd5;

  // entry states
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;

  // event kinds
  localparam logic [1:0] EV_REPLY   = 2'd0;
  localparam logic [1:0] EV_EXPIRE  = 2'd1;
  localparam logic [1:0] EV_SUMMARY = 2'd2;

  // reply status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_DENIED = 2'd2;
  localparam logic [1:0] STAT_RANGE  = 2'd3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd32;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [ID_W-1:0]   result_id;
    logic [1:0]        status;
    logic [WORD_W-1:0] time_left;
    logic              is_running;
    logic              is_present;
    logic [WORD_W-1:0] next_wait;
    logic              last;
  } result_t;

  // control between the sequencer and the entry memory
  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tpe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the timer pool engine command and
// result streams. Field widths follow tpe_pkg.
interface tpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpe_pkg::CMD_W-1:0]   cmd;
  logic [tpe_pkg::ID_W-1:0]    timer_id;
  logic [tpe_pkg::WORD_W-1:0]  timeout;
  logic [tpe_pkg::WORD_W-1:0]  elapsed_ticks;

  modport source (output valid, cmd, timer_id, timeout, elapsed_ticks, input ready);
  modport sink   (input valid, cmd, timer_id, timeout, elapsed_ticks, output ready);
endinterface

interface tpe_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  event_kind;
  logic [tpe_pkg::ID_W-1:0]    result_id;
  logic [1:0]                  status;
  logic [tpe_pkg::WORD_W-1:0]  time_left;
  logic                        is_running;
  logic                        is_present;
  logic [tpe_pkg::WORD_W-1:0]  next_wait;
  logic                        last;

  modport source (output valid, event_kind, result_id, status, time_left, is_running,
                  is_present, next_wait, last, input ready);
  modport sink   (input valid, event_kind, result_id, status, time_left, is_running,
                  is_present, next_wait, last, output ready);
endinterface

`default_nettype wire

// File: rtl/tpe_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Timer entry store: one synchronous RAM word per entry {state, fresh, count}
// with a registered read and per-entry valid bits. Uses tpe_pkg.
module tpe_entry_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 35
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpe_pkg::mem_ctl_t ctl,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // RAM array, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr[IDX_W-1:0]];
    end
  end

  // valid bits: an unwritten entry reads as free with zero count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[ctl.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[ctl.rd_addr[IDX_W-1:0]];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// File: rtl/tpe_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-entry update for one command: next state, fresh flag and count of the
// entry just read, plus write, hit, expiry and status flags. Uses tpe_pkg.
module tpe_eval #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic [tpe_pkg::CMD_W-1:0]  cmd,
  input  wire logic [1:0]                 ent_state,
  input  wire logic                       ent_fresh,
  input  wire logic [COUNT_WIDTH-1:0]     ent_count,
  input  wire logic [COUNT_WIDTH-1:0]     tmo,
  input  wire logic [tpe_pkg::WORD_W-1:0] ela,
  output logic [1:0]                      nxt_state,
  output logic                            nxt_fresh,
  output logic [COUNT_WIDTH-1:0]          nxt_count,
  output logic                            wr,
  output logic                            hit,
  output logic                            expire,
  output logic [1:0]                      status
);

  logic due;

  // counter at or below the elapsed ticks
  assign due = (tpe_pkg::WORD_W'(ent_count) <= ela);

  always_comb begin
    nxt_state = ent_state;
    nxt_fresh = ent_fresh;
    nxt_count = ent_count;
    wr        = 1'b0;
    hit       = 1'b0;
    expire    = 1'b0;
    status    = tpe_pkg::STAT_OK;
    case (cmd)
      tpe_pkg::CMD_ALLOC: begin
        if (ent_state == tpe_pkg::ST_FREE) begin
          hit       = 1'b1;
          wr        = 1'b1;
          nxt_state = tpe_pkg::ST_RESERVED;
          nxt_fresh = 1'b0;
          nxt_count = '0;
        end
      end
      tpe_pkg::CMD_FREE: begin
        wr        = 1'b1;
        nxt_state = tpe_pkg::ST_FREE;
        nxt_fresh = 1'b0;
        nxt_count = '0;
      end
      tpe_pkg::CMD_START: begin
        if (ent_state == tpe_pkg::ST_RESERVED) begin
          wr        = 1'b1;
          nxt_state = tpe_pkg::ST_RUNNING;
          nxt_count = tmo;
          nxt_fresh = (tmo != '0);
        end else begin
          status = tpe_pkg::STAT_DENIED;
        end
      end
      tpe_pkg::CMD_STOP: begin
        if (ent_state == tpe_pkg::ST_RUNNING) begin
          wr        = 1'b1;
          nxt_state = tpe_pkg::ST_RESERVED;
        end
      end
      tpe_pkg::CMD_TICK: begin
        // charge running, non-fresh entries; fresh flag always clears
        wr        = 1'b1;
        nxt_fresh = 1'b0;
        if (ent_state == tpe_pkg::ST_RUNNING && !ent_fresh) begin
          if (due) begin
            expire    = 1'b1;
            nxt_state = tpe_pkg::ST_RESERVED;
            nxt_count = '0;
          end else begin
            nxt_count = ent_count - ela[COUNT_WIDTH-1:0];
          end
        end
      end
      default: begin
        // query: read only
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/timer_pool_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Timer pool engine top level: command sequencer, entry scan and output
// register around tpe_entry_mem and tpe_eval. Uses tpe_pkg and tpe_if.
//
// Usage:
//   in_chan  (sink)   : one command beat (cmd, timer_id, timeout, elapsed_ticks).
//   out_chan (source) : result beats; the final beat of a command has last = 1.
//   cfg_we/cfg_wdata  : writes active_timers; only while the engine is idle.
// One command is in work at a time; in_chan.ready is high only when idle.
// Free, start, stop and query read their entry from the RAM the cycle they
// are accepted and load their reply beat into the output register in the
// next state, once it is free. Unknown commands and out-of-range ids reply
// alike with no RAM read. Tick and allocate scan the entry RAM one entry a
// cycle, with the read of the next entry overlapped with the update of the
// current one: a tick gives one expiry beat per expired entry and a summary
// beat at the end; allocate stops at the first free entry.
// The RAM port (one read, one write per cycle) sets this pace.
// A stalled receiver holds the output register; the scan pauses on the entry
// that needs to emit and resumes when the beat is taken.
// Reset: all entries free and zero (valid bits, no clearing pass), output
// empty, active_timers = 32.
module timer_pool_engine_core #(
  parameter int NUM_TIMERS  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  tpe_in_if.sink                         in_chan,
  tpe_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [tpe_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH  = (NUM_TIMERS > 32) ? 32 : NUM_TIMERS;
  localparam int DATA_W = COUNT_WIDTH + 3;
  localparam logic [tpe_pkg::WORD_W-1:0] CMAX =
    tpe_pkg::WORD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ONE    = 3'd1;
  localparam logic [2:0] S_DIRECT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [tpe_pkg::CFG_W-1:0]      act_r;
  logic [tpe_pkg::CNT_W-1:0]      n_r, n_nxt, pool_n;
  logic [tpe_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [tpe_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [COUNT_WIDTH-1:0]         tmo_r, tmo_nxt;
  logic [tpe_pkg::WORD_W-1:0]     ela_r, ela_nxt;
  logic [1:0]                     dstat_r, dstat_nxt;
  logic [tpe_pkg::CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                           p_vld_r, p_vld_nxt;
  logic [tpe_pkg::ID_W-1:0]       p_idx_r, p_idx_nxt;
  logic [COUNT_WIDTH-1:0]         best_r, best_nxt;
  tpe_pkg::result_t               out_r, out_nxt;
  logic                           out_vld_r, out_vld_nxt;

  tpe_pkg::mem_ctl_t              mem_ctl;
  logic [DATA_W-1:0]              rd_data;
  logic [DATA_W-1:0]              wr_data;

  logic [1:0]                     ev_state;
  logic                           ev_fresh;
  logic [COUNT_WIDTH-1:0]         ev_count;
  logic                           ev_wr, ev_hit, ev_expire;
  logic [1:0]                     ev_status;

  logic                           accept, out_free, emit, advance;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_vld_r || out_chan.ready;
  assign pool_n   = (act_r > tpe_pkg::CNT_W'(DEPTH)) ? tpe_pkg::CNT_W'(DEPTH) : act_r;

  // entry storage
  tpe_entry_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // entry update for the word just read
  tpe_eval #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_eval (
    .cmd       (cmd_r),
    .ent_state (rd_data[DATA_W-1 -: 2]),
    .ent_fresh (rd_data[COUNT_WIDTH]),
    .ent_count (rd_data[COUNT_WIDTH-1:0]),
    .tmo       (tmo_r),
    .ela       (ela_r),
    .nxt_state (ev_state),
    .nxt_fresh (ev_fresh),
    .nxt_count (ev_count),
    .wr        (ev_wr),
    .hit       (ev_hit),
    .expire    (ev_expire),
    .status    (ev_status)
  );

  assign wr_data = {ev_state, ev_fresh, ev_count};

  // scan may move on unless the current entry must emit into a full register
  assign advance = !(p_vld_r && ev_expire && !out_free);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    tmo_nxt    = tmo_r;
    ela_nxt    = ela_r;
    dstat_nxt  = dstat_r;
    rd_idx_nxt = rd_idx_r;
    p_vld_nxt  = p_vld_r;
    p_idx_nxt  = p_idx_r;
    best_nxt   = best_r;
    emit       = 1'b0;
    out_nxt    = '0;
    mem_ctl    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_nxt      = pool_n;
          cmd_nxt    = in_chan.cmd;
          id_nxt     = in_chan.timer_id;
          tmo_nxt    = (in_chan.timeout > CMAX) ? CMAX[COUNT_WIDTH-1:0]
                                                : in_chan.timeout[COUNT_WIDTH-1:0];
          ela_nxt    = in_chan.elapsed_ticks;
          rd_idx_nxt = '0;
          p_vld_nxt  = 1'b0;
          best_nxt   = '0;
          if (in_chan.cmd == tpe_pkg::CMD_ALLOC || in_chan.cmd == tpe_pkg::CMD_TICK) begin
            state_nxt = S_SCAN;
          end else if (in_chan.cmd > tpe_pkg::CMD_TICK) begin
            dstat_nxt = tpe_pkg::STAT_DENIED;
            state_nxt = S_DIRECT;
          end else if (tpe_pkg::CNT_W'(in_chan.timer_id) >= pool_n) begin
            dstat_nxt = tpe_pkg::STAT_RANGE;
            state_nxt = S_DIRECT;
          end else begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = in_chan.timer_id;
            state_nxt       = S_ONE;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          mem_ctl.wr_en   = ev_wr;
          mem_ctl.wr_addr = id_r;
          emit              = 1'b1;
          out_nxt.result_id = id_r;
          out_nxt.status    = ev_status;
          out_nxt.last      = 1'b1;
          if (cmd_r == tpe_pkg::CMD_QUERY) begin
            out_nxt.time_left  = tpe_pkg::WORD_W'(rd_data[COUNT_WIDTH-1:0]);
            out_nxt.is_running = (rd_data[DATA_W-1 -: 2] == tpe_pkg::ST_RUNNING);
            out_nxt.is_present = (rd_data[DATA_W-1 -: 2] != tpe_pkg::ST_FREE);
          end
          state_nxt = S_IDLE;
        end
      end
      S_DIRECT: begin
        if (out_free) begin
          emit              = 1'b1;
          out_nxt.result_id = id_r;
          out_nxt.status    = dstat_r;
          out_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cmd_r == tpe_pkg::CMD_ALLOC && p_vld_r && ev_hit) begin
          // first free entry: reserve it and finish
          if (out_free) begin
            mem_ctl.wr_en     = 1'b1;
            mem_ctl.wr_addr   = p_idx_r;
            emit              = 1'b1;
            out_nxt.result_id = p_idx_r;
            out_nxt.status    = tpe_pkg::STAT_OK;
            out_nxt.last      = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else if (advance) begin
          // retire the entry in hand (tick only)
          if (p_vld_r && cmd_r == tpe_pkg::CMD_TICK) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = p_idx_r;
            if (ev_expire) begin
              emit               = 1'b1;
              out_nxt.event_kind = tpe_pkg::EV_EXPIRE;
              out_nxt.result_id  = p_idx_r;
            end
            if (ev_state == tpe_pkg::ST_RUNNING &&
                (best_r == '0 || ev_count < best_r)) begin
              best_nxt = ev_count;
            end
          end
          // fetch the next entry
          if (rd_idx_r < n_r) begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = rd_idx_r[tpe_pkg::ID_W-1:0];
            p_vld_nxt       = 1'b1;
            p_idx_nxt       = rd_idx_r[tpe_pkg::ID_W-1:0];
            rd_idx_nxt      = rd_idx_r + 1'b1;
          end else begin
            p_vld_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit         = 1'b1;
          out_nxt.last = 1'b1;
          if (cmd_r == tpe_pkg::CMD_TICK) begin
            out_nxt.event_kind = tpe_pkg::EV_SUMMARY;
            out_nxt.next_wait  = tpe_pkg::WORD_W'(best_r);
          end else begin
            out_nxt.status = tpe_pkg::STAT_FULL;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      act_r     <= tpe_pkg::ACTIVE_RESET;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
    end
  end

  // command and scan payload
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    tmo_r    <= tmo_nxt;
    ela_r    <= ela_nxt;
    dstat_r  <= dstat_nxt;
    rd_idx_r <= rd_idx_nxt;
    p_idx_r  <= p_idx_nxt;
    best_r   <= best_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  // channel wiring
  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_vld_r;
  assign out_chan.event_kind = out_r.event_kind;
  assign out_chan.result_id  = out_r.result_id;
  assign out_chan.status     = out_r.status;
  assign out_chan.time_left  = out_r.time_left;
  assign out_chan.is_running = out_r.is_running;
  assign out_chan.is_present = out_r.is_present;
  assign out_chan.next_wait  = out_r.next_wait;
  assign out_chan.last       = out_r.last;

`ifndef SYNTHESIS
  // every accepted command takes the engine out of idle in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted command did not leave idle");

  // expiry beats are never the final beat of a tick
  a_expire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.event_kind == tpe_pkg::EV_EXPIRE) |-> !out_r.last)
    else $error("expiry beat marked last");

  // RAM writes only come from the single-entry or scan states
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (state_r == S_ONE || state_r == S_SCAN))
    else $error("entry write outside an update state");

  // scan never fetches past the active pool
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= n_r))
    else $error("scan index beyond pool size");
`endif

endmodule

`default_nettype wire
